/* src/assert_macros.svh */
// assertion macros shared by the closest hit core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

/* src/rsch_pkg.sv */
// types, constants and helper functions of the ray sphere closest hit core
// no dependencies
package rsch_pkg;

    localparam int COORD_W   = 32;
    localparam int DIST_W    = 31;
    localparam int IDX_W     = 4;
    localparam int COW       = 33;
    localparam int OPW       = 68;
    localparam int PRODW     = 136;
    localparam int SW        = 68;
    localparam int NUMW      = 69;
    localparam int NUM_SW    = 70;
    localparam int DENW      = 64;
    localparam int MUL_DIG   = 8;
    localparam int MUL_STEPS = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [DIST_W-1:0] DIST_ONES            = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] PRIMARY_NEAR_RESET   = 31'd65536;
    localparam logic [DIST_W-1:0] SECONDARY_NEAR_RESET = 31'd66;

    typedef logic signed [OPW-1:0]   t_op;
    typedef logic signed [PRODW-1:0] t_prod;

    typedef enum logic [1:0] {
        CMD_CLEAR     = 2'd0,
        CMD_APPEND    = 2'd1,
        CMD_PRIMARY   = 2'd2,
        CMD_SECONDARY = 2'd3
    } t_command;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRIMARY_NEAR   = 1'b0,
        CFG_SECONDARY_NEAR = 1'b1
    } t_cfg_index;

    typedef enum logic [3:0] {
        MS_DXDX, MS_DYDY, MS_DZDZ,
        MS_CXDX, MS_CYDY, MS_CZDZ,
        MS_CXCX, MS_CYCY, MS_CZCZ, MS_RR,
        MS_HH,   MS_AC
    } t_mul_sel;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_A_CHECK, ST_SPHERE_CHECK, ST_CO,
        ST_DISC_CHECK, ST_SQRT_GO, ST_SQRT_WAIT, ST_DIV_GO, ST_DIV_WAIT,
        ST_NEXT, ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [DIST_W-1:0]         radius;
    } t_entry;

    typedef struct packed {
        logic     accept;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     co_load;
        logic     sqrt_start;
        logic     div_start;
        logic     div_root;
        logic     k_inc;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
        logic sqrt_done;
        logic div_done;
        logic a_zero;
        logic disc_neg;
        logic more;
    } t_dp_stat;

    // product starts a fresh sum
    function automatic logic sel_first(input t_mul_sel s);
        return (s == MS_DXDX) || (s == MS_CXDX) || (s == MS_CXCX) || (s == MS_HH);
    endfunction

    // product is subtracted from the running sum
    function automatic logic sel_sub(input t_mul_sel s);
        return (s == MS_RR) || (s == MS_AC);
    endfunction

    function automatic t_mul_sel next_sel(input t_mul_sel s);
        t_mul_sel n;
        unique case (s)
            MS_DXDX: n = MS_DYDY;
            MS_DYDY: n = MS_DZDZ;
            MS_CXDX: n = MS_CYDY;
            MS_CYDY: n = MS_CZDZ;
            MS_CZDZ: n = MS_CXCX;
            MS_CXCX: n = MS_CYCY;
            MS_CYCY: n = MS_CZCZ;
            MS_CZCZ: n = MS_RR;
            MS_RR:   n = MS_HH;
            MS_HH:   n = MS_AC;
            default: n = MS_DXDX;
        endcase
        return n;
    endfunction

endpackage

/* src/rsch_mul.sv */
// shared signed multiplier, eight bits of the second operand per cycle
// depends on rsch_pkg
module rsch_mul import rsch_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_op   i_a,
    input  t_op   i_b,
    output logic  o_done,
    output t_prod o_prod
);

    localparam int BW   = MUL_DIG * MUL_STEPS;
    localparam int ACCW = OPW + BW;
    localparam int PPW  = OPW + MUL_DIG;

    logic [OPW-1:0]  r_ma;
    logic [BW-1:0]   r_mb;
    logic [ACCW-1:0] r_acc;
    logic            r_neg;
    logic [3:0]      r_cnt;
    logic            r_run;
    logic            r_fix;
    logic            r_done;
    t_prod           r_prod;

    logic [OPW-1:0] abs_a;
    logic [OPW-1:0] abs_b;
    logic [PPW-1:0] pp;

    assign abs_a = i_a[OPW-1] ? OPW'(-i_a) : OPW'(i_a);
    assign abs_b = i_b[OPW-1] ? OPW'(-i_b) : OPW'(i_b);
    assign pp    = {{MUL_DIG{1'b0}}, r_ma} * {{OPW{1'b0}}, r_mb[BW-1 -: MUL_DIG]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run) begin
                if (r_cnt == 4'(MUL_STEPS - 1)) begin
                    r_run <= 1'b0;
                    r_fix <= 1'b1;
                end
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= abs_a;
            r_mb  <= BW'(abs_b);
            r_acc <= '0;
            r_neg <= i_a[OPW-1] ^ i_b[OPW-1];
            r_cnt <= '0;
        end else if (r_run) begin
            r_acc <= (r_acc << MUL_DIG) + ACCW'(pp);
            r_mb  <= r_mb << MUL_DIG;
            r_cnt <= r_cnt + 4'd1;
        end else if (r_fix) begin
            r_prod <= r_neg ? PRODW'(-r_acc) : PRODW'(r_acc);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

/* src/rsch_isqrt.sv */
// integer square root, one result bit per cycle
// depends on rsch_pkg
module rsch_isqrt import rsch_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_prod         i_v,
    output logic          o_done,
    output logic [SW-1:0] o_root
);

    localparam int SQW   = PRODW;
    localparam int STEPS = SQW / 2;
    localparam int CNTW  = $clog2(STEPS);

    logic [SQW-1:0]  r_v;
    logic [SQW-1:0]  r_res;
    logic [SQW-1:0]  r_bit;
    logic [CNTW-1:0] r_cnt;
    logic            r_run;
    logic            r_done;

    logic [SQW-1:0] trial;
    logic           ge;

    assign trial = r_res + r_bit;
    assign ge    = r_v >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == CNTW'(STEPS - 1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= SQW'(i_v);
            r_res <= '0;
            r_bit <= SQW'(1) << (SQW - 2);
            r_cnt <= '0;
        end else if (r_run) begin
            if (ge) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[SW-1:0];

endmodule

/* src/rsch_div.sv */
// saturating fixed point divider, one quotient bit per cycle
// depends on rsch_pkg
module rsch_div import rsch_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUMW-1:0]   i_num,
    input  logic [DENW-1:0]   i_den,
    output logic              o_done,
    output logic [DIST_W-1:0] o_quot
);

    localparam int DW   = NUMW + FRACTION_BITS + DIST_W;
    localparam int CNTW = $clog2(DIST_W);

    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_den;
    logic [DIST_W-1:0] r_q;
    logic              r_sat;
    logic [CNTW-1:0]   r_cnt;
    logic              r_run;
    logic              r_done;

    logic [DW-1:0] num_sh;
    logic [DW-1:0] den_top;
    logic          sat;
    logic          ge;

    assign num_sh  = DW'(i_num) << FRACTION_BITS;
    assign den_top = DW'(i_den) << DIST_W;
    assign sat     = num_sh >= den_top;
    assign ge      = r_rem >= r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= !sat;
                r_done <= sat;
            end else if (r_run && r_cnt == CNTW'(DIST_W - 1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= num_sh;
            r_den <= DW'(i_den) << (DIST_W - 1);
            r_q   <= '0;
            r_sat <= sat;
            r_cnt <= '0;
        end else if (r_run) begin
            if (ge) begin
                r_rem <= r_rem - r_den;
            end
            r_q   <= {r_q[DIST_W-2:0], ge};
            r_den <= r_den >> 1;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? DIST_ONES : r_q;

endmodule

/* src/rsch_dp.sv */
// datapath: sphere table, query registers, quadratic terms and closest hit tracking
// depends on rsch_pkg, rsch_mul, rsch_isqrt, rsch_div
module rsch_dp import rsch_pkg::*; #(
    parameter int MAX_SPHERES   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_stat                  o_stat,
    input  logic                      i_cfg_write,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [DIST_W-1:0]         i_cfg_data,
    input  logic [1:0]                i_command,
    input  logic signed [COORD_W-1:0] i_center_x,
    input  logic signed [COORD_W-1:0] i_center_y,
    input  logic signed [COORD_W-1:0] i_center_z,
    input  logic [DIST_W-1:0]         i_sphere_radius,
    input  logic signed [COORD_W-1:0] i_origin_x,
    input  logic signed [COORD_W-1:0] i_origin_y,
    input  logic signed [COORD_W-1:0] i_origin_z,
    input  logic signed [COORD_W-1:0] i_dir_x,
    input  logic signed [COORD_W-1:0] i_dir_y,
    input  logic signed [COORD_W-1:0] i_dir_z,
    input  logic [DIST_W-1:0]         i_far_limit,
    output logic                      o_hit,
    output logic [IDX_W-1:0]          o_sphere_index,
    output logic [DIST_W-1:0]         o_hit_distance,
    output logic                      o_load_status
);

    localparam int IW  = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CW  = $clog2(MAX_SPHERES + 1);
    localparam int KXW = CW + IDX_W;

    t_entry mem [MAX_SPHERES];
    t_entry r_ent;

    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_k;
    logic [DIST_W-1:0]         r_primary_near;
    logic [DIST_W-1:0]         r_secondary_near;
    logic signed [COORD_W-1:0] r_ox, r_oy, r_oz;
    logic signed [COORD_W-1:0] r_dx, r_dy, r_dz;
    logic [DIST_W-1:0]         r_far;
    logic [DIST_W-1:0]         r_near;
    logic signed [COW-1:0]     r_cox, r_coy, r_coz;
    t_op                       r_a, r_h, r_c;
    t_prod                     r_acc;
    t_prod                     r_disc;
    logic [SW-1:0]             r_s;
    logic                      r_num_neg;
    logic                      r_hit;
    logic [IDX_W-1:0]          r_idx;
    logic [DIST_W-1:0]         r_dist;
    logic                      r_status;

    t_command           cmd;
    logic               room;
    t_entry             new_ent;
    t_op                mul_a, mul_b;
    logic               mul_done;
    t_prod              mul_prod;
    t_prod              acc_base;
    t_prod              acc_sum;
    logic               sqrt_done;
    logic [SW-1:0]      sqrt_root;
    logic signed [NUM_SW-1:0] h_ext, s_ext, num;
    logic               div_done;
    logic [DIST_W-1:0]  div_q;
    logic               take;
    logic [KXW-1:0]     k_ext;

    assign cmd     = t_command'(i_command);
    assign room    = r_count < CW'(MAX_SPHERES);
    assign new_ent = '{cx: i_center_x, cy: i_center_y, cz: i_center_z,
                       radius: i_sphere_radius};

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && cmd == CMD_APPEND && room) begin
            mem[r_count[IW-1:0]] <= new_ent;
        end
        r_ent <= mem[r_k[IW-1:0]];
    end

    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_DXDX: begin mul_a = OPW'(r_dx);  mul_b = OPW'(r_dx);  end
            MS_DYDY: begin mul_a = OPW'(r_dy);  mul_b = OPW'(r_dy);  end
            MS_DZDZ: begin mul_a = OPW'(r_dz);  mul_b = OPW'(r_dz);  end
            MS_CXDX: begin mul_a = OPW'(r_cox); mul_b = OPW'(r_dx);  end
            MS_CYDY: begin mul_a = OPW'(r_coy); mul_b = OPW'(r_dy);  end
            MS_CZDZ: begin mul_a = OPW'(r_coz); mul_b = OPW'(r_dz);  end
            MS_CXCX: begin mul_a = OPW'(r_cox); mul_b = OPW'(r_cox); end
            MS_CYCY: begin mul_a = OPW'(r_coy); mul_b = OPW'(r_coy); end
            MS_CZCZ: begin mul_a = OPW'(r_coz); mul_b = OPW'(r_coz); end
            MS_RR: begin
                mul_a = $signed({{(OPW-DIST_W){1'b0}}, r_ent.radius});
                mul_b = $signed({{(OPW-DIST_W){1'b0}}, r_ent.radius});
            end
            MS_HH:   begin mul_a = r_h; mul_b = r_h; end
            MS_AC:   begin mul_a = r_a; mul_b = r_c; end
            default: begin mul_a = '0;  mul_b = '0;  end
        endcase
    end

    rsch_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    assign acc_base = sel_first(i_cmd.mul_sel) ? '0 : r_acc;
    assign acc_sum  = sel_sub(i_cmd.mul_sel) ? acc_base - mul_prod : acc_base + mul_prod;

    rsch_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_v     (r_disc),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    assign h_ext = NUM_SW'(r_h);
    assign s_ext = $signed({{(NUM_SW-SW){1'b0}}, r_s});
    assign num   = i_cmd.div_root ? (-h_ext - s_ext) : (s_ext - h_ext);

    rsch_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num[NUMW-1:0]),
        .i_den   (r_a[DENW-1:0]),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign take = !r_num_neg && (div_q >= r_near)
                  && ((r_far == DIST_ONES) || (div_q <= r_far))
                  && (!r_hit || (div_q < r_dist));
    assign k_ext = KXW'(r_k);

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count          <= '0;
            r_primary_near   <= PRIMARY_NEAR_RESET;
            r_secondary_near <= SECONDARY_NEAR_RESET;
            r_hit            <= 1'b0;
            r_status         <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                unique case (i_cfg_index)
                    CFG_PRIMARY_NEAR:   r_primary_near   <= i_cfg_data;
                    CFG_SECONDARY_NEAR: r_secondary_near <= i_cfg_data;
                    default:            r_primary_near   <= r_primary_near;
                endcase
            end
            if (i_cmd.accept) begin
                r_hit    <= 1'b0;
                r_status <= (cmd == CMD_APPEND) && !room;
                if (cmd == CMD_CLEAR) begin
                    r_count <= '0;
                end else if (cmd == CMD_APPEND && room) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (div_done && take) begin
                r_hit <= 1'b1;
            end
        end
    end

    // query payload, per sphere terms and closest hit record
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ox   <= i_origin_x;
            r_oy   <= i_origin_y;
            r_oz   <= i_origin_z;
            r_dx   <= i_dir_x;
            r_dy   <= i_dir_y;
            r_dz   <= i_dir_z;
            r_far  <= i_far_limit;
            r_near <= (cmd == CMD_PRIMARY) ? r_primary_near : r_secondary_near;
            r_k    <= '0;
            r_idx  <= '0;
            r_dist <= DIST_ONES;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.co_load) begin
            r_cox <= COW'(r_ox) - COW'(r_ent.cx);
            r_coy <= COW'(r_oy) - COW'(r_ent.cy);
            r_coz <= COW'(r_oz) - COW'(r_ent.cz);
        end
        if (mul_done) begin
            r_acc <= acc_sum;
            if (i_cmd.mul_sel == MS_DZDZ) r_a <= OPW'(acc_sum);
            if (i_cmd.mul_sel == MS_CZDZ) r_h <= OPW'(acc_sum);
            if (i_cmd.mul_sel == MS_RR)   r_c <= OPW'(acc_sum);
            if (i_cmd.mul_sel == MS_AC)   r_disc <= acc_sum;
        end
        if (sqrt_done) begin
            r_s <= sqrt_root;
        end
        if (i_cmd.div_start) begin
            r_num_neg <= num[NUM_SW-1];
        end
        if (div_done && take && !i_cmd.accept) begin
            r_dist <= div_q;
            r_idx  <= k_ext[IDX_W-1:0];
        end
    end

    assign o_stat.mul_done  = mul_done;
    assign o_stat.sqrt_done = sqrt_done;
    assign o_stat.div_done  = div_done;
    assign o_stat.a_zero    = (r_a == '0);
    assign o_stat.disc_neg  = r_disc[PRODW-1];
    assign o_stat.more      = r_k < r_count;

    assign o_hit          = r_hit;
    assign o_sphere_index = r_idx;
    assign o_hit_distance = r_dist;
    assign o_load_status  = r_status;

endmodule

/* src/rsch_ctrl.sv */
// controller: sequences the table commands and the per sphere solve
// depends on rsch_pkg
module rsch_ctrl import rsch_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_command,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_result_valid
);

    t_state   r_state, n_state;
    t_mul_sel r_sel, n_sel;
    logic     r_root, n_root;
    t_command cmd;

    assign cmd = t_command'(i_command);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel   <= MS_DXDX;
            r_root  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_root  <= n_root;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_sel           = r_sel;
        n_root          = r_root;
        o_cmd           = '0;
        o_cmd.mul_sel   = r_sel;
        o_cmd.div_root  = r_root;
        o_busy          = 1'b1;
        o_result_valid  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (cmd == CMD_PRIMARY || cmd == CMD_SECONDARY) begin
                        n_sel   = MS_DXDX;
                        n_state = ST_MUL_GO;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_MUL_GO: begin
                o_cmd.mul_start = 1'b1;
                n_state         = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (i_stat.mul_done) begin
                    if (r_sel == MS_DZDZ) begin
                        n_state = ST_A_CHECK;
                    end else if (r_sel == MS_AC) begin
                        n_state = ST_DISC_CHECK;
                    end else begin
                        n_sel   = next_sel(r_sel);
                        n_state = ST_MUL_GO;
                    end
                end
            end
            ST_A_CHECK: begin
                n_state = i_stat.a_zero ? ST_DONE : ST_SPHERE_CHECK;
            end
            ST_SPHERE_CHECK: begin
                n_state = i_stat.more ? ST_CO : ST_DONE;
            end
            ST_CO: begin
                o_cmd.co_load = 1'b1;
                n_sel         = MS_CXDX;
                n_state       = ST_MUL_GO;
            end
            ST_DISC_CHECK: begin
                n_state = i_stat.disc_neg ? ST_NEXT : ST_SQRT_GO;
            end
            ST_SQRT_GO: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (i_stat.sqrt_done) begin
                    n_root  = 1'b0;
                    n_state = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    if (!r_root) begin
                        n_root  = 1'b1;
                        n_state = ST_DIV_GO;
                    end else begin
                        n_state = ST_NEXT;
                    end
                end
            end
            ST_NEXT: begin
                o_cmd.k_inc = 1'b1;
                n_state     = ST_SPHERE_CHECK;
            end
            ST_DONE: begin
                o_result_valid = 1'b1;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/ray_sphere_closest_hit_core.sv */
// top level of the ray sphere closest hit core
// depends on rsch_pkg, rsch_ctrl, rsch_dp and assert_macros.svh
//
// channel    | direction | handshake                 | beat
// command    | in        | start / busy              | command, sphere or ray fields
// result     | out       | o_result_valid strobe     | hit, index, distance, load status
// config     | in        | i_cfg_valid / o_cfg_ready | register index, data
//
// clear and append: result strobe in the cycle after the accepting edge
// queries: the stored spheres are solved one after another with the shared
// 8-bit-digit multiplier, the bit-serial square root and the bit-serial divider
// busy stays high until the result strobe cycle ends; reset is synchronous, active low
// config writes are taken in any cycle; the result side cannot stall
`include "assert_macros.svh"

module ray_sphere_closest_hit_core import rsch_pkg::*; #(
    parameter int MAX_SPHERES   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_command,
    input  logic signed [COORD_W-1:0] i_center_x,
    input  logic signed [COORD_W-1:0] i_center_y,
    input  logic signed [COORD_W-1:0] i_center_z,
    input  logic [DIST_W-1:0]         i_sphere_radius,
    input  logic signed [COORD_W-1:0] i_origin_x,
    input  logic signed [COORD_W-1:0] i_origin_y,
    input  logic signed [COORD_W-1:0] i_origin_z,
    input  logic signed [COORD_W-1:0] i_dir_x,
    input  logic signed [COORD_W-1:0] i_dir_y,
    input  logic signed [COORD_W-1:0] i_dir_z,
    input  logic [DIST_W-1:0]         i_far_limit,
    output logic                      o_result_valid,
    output logic                      o_hit,
    output logic [IDX_W-1:0]          o_sphere_index,
    output logic [DIST_W-1:0]         o_hit_distance,
    output logic                      o_load_status,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [DIST_W-1:0]         i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    rsch_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_command      (i_command),
        .i_stat         (dp_stat),
        .o_cmd          (dp_cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    rsch_dp #(
        .MAX_SPHERES   (MAX_SPHERES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_cfg_write     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_command       (i_command),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_center_z      (i_center_z),
        .i_sphere_radius (i_sphere_radius),
        .i_origin_x      (i_origin_x),
        .i_origin_y      (i_origin_y),
        .i_origin_z      (i_origin_z),
        .i_dir_x         (i_dir_x),
        .i_dir_y         (i_dir_y),
        .i_dir_z         (i_dir_z),
        .i_far_limit     (i_far_limit),
        .o_hit           (o_hit),
        .o_sphere_index  (o_sphere_index),
        .o_hit_distance  (o_hit_distance),
        .o_load_status   (o_load_status)
    );

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_IMPLIES(a_strobe_busy, i_clk, i_rst_n, o_result_valid, busy)
    `ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_result_valid, !busy && !o_result_valid)
    `ASSERT_IMPLIES(a_miss_fields, i_clk, i_rst_n, o_result_valid && !o_hit, o_sphere_index == '0 && o_hit_distance == DIST_ONES)

endmodule

/* tb/tb_ray_sphere_closest_hit_core.sv */
// testbench for ray_sphere_closest_hit_core: directed and random sphere loads and ray queries,
// predicted with exact wide integer math in a small scoreboard class
// depends on rsch_pkg and the core rtl
`timescale 1ns / 1ps

module tb_ray_sphere_closest_hit_core;
    import rsch_pkg::*;

    localparam int N_SLOTS     = 16;
    localparam int FRAC        = 16;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam logic signed [31:0] UNIT = 32'sd65536;

    typedef logic signed [191:0] t_wide;

    typedef struct {
        t_command           cmd;
        logic signed [31:0] cx, cy, cz;
        logic [30:0]        radius;
        logic signed [31:0] ox, oy, oz;
        logic signed [31:0] dx, dy, dz;
        logic [30:0]        far_lim;
    } t_beat;

    typedef struct {
        logic        hit;
        logic [3:0]  idx;
        logic [30:0] distance;
        logic        status;
    } t_hit;

    class hit_scoreboard;
        logic signed [31:0] tab_x[N_SLOTS], tab_y[N_SLOTS], tab_z[N_SLOTS];
        logic [30:0]        tab_r[N_SLOTS];
        int                 count;
        logic [30:0]        near_primary, near_secondary;
        t_hit               pending_hits[$];
        int                 errors;

        function new();
            count = 0;
            near_primary = PRIMARY_NEAR_RESET;
            near_secondary = SECONDARY_NEAR_RESET;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_index idx, logic [30:0] val);
            if (idx == CFG_PRIMARY_NEAR) near_primary = val;
            else near_secondary = val;
        endfunction

        function t_wide isqrt(t_wide v);
            t_wide res, bitv, t;
            res = '0;
            bitv = t_wide'(1) << 190;
            while (bitv != 0 && $unsigned(bitv) > $unsigned(v)) bitv = bitv >> 2;
            while (bitv != 0) begin
                t = res + bitv;
                if ($unsigned(v) >= $unsigned(t)) begin
                    v = v - t;
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function t_hit trace(t_beat b);
            t_hit  r;
            t_wide dx, dy, dz, a, cx, cy, cz, rr, h, c, disc, s, num, q;
            logic [30:0] near_lim, t;
            r = '{hit: 1'b0, idx: '0, distance: DIST_ONES, status: 1'b0};
            near_lim = (b.cmd == CMD_PRIMARY) ? near_primary : near_secondary;
            dx = t_wide'(b.dx); dy = t_wide'(b.dy); dz = t_wide'(b.dz);
            a = dx * dx + dy * dy + dz * dz;
            if (a == 0) return r;
            for (int k = 0; k < count; k++) begin
                cx = t_wide'(b.ox); cx = cx - t_wide'(tab_x[k]);
                cy = t_wide'(b.oy); cy = cy - t_wide'(tab_y[k]);
                cz = t_wide'(b.oz); cz = cz - t_wide'(tab_z[k]);
                rr = t_wide'({1'b0, tab_r[k]});
                h = cx * dx + cy * dy + cz * dz;
                c = cx * cx + cy * cy + cz * cz - rr * rr;
                disc = h * h - a * c;
                if (disc[191]) continue;
                s = isqrt(disc);
                for (int j = 0; j < 2; j++) begin
                    num = (j == 0) ? s - h : -h - s;
                    if (num[191]) continue;
                    q = t_wide'($unsigned(num << FRAC) / $unsigned(a));
                    t = ($unsigned(q) > 192'h7FFF_FFFF) ? DIST_ONES : q[30:0];
                    if (t < near_lim) continue;
                    if (b.far_lim != DIST_ONES && t > b.far_lim) continue;
                    if (!r.hit || t < r.distance) begin
                        r.hit = 1'b1;
                        r.distance = t;
                        r.idx = k[3:0];
                    end
                end
            end
            return r;
        endfunction

        function void note_beat(t_beat b);
            t_hit r;
            r = '{hit: 1'b0, idx: '0, distance: DIST_ONES, status: 1'b0};
            case (b.cmd)
                CMD_CLEAR: count = 0;
                CMD_APPEND: begin
                    if (count < N_SLOTS) begin
                        tab_x[count] = b.cx;
                        tab_y[count] = b.cy;
                        tab_z[count] = b.cz;
                        tab_r[count] = b.radius;
                        count++;
                    end else begin
                        r.status = 1'b1;
                    end
                end
                default: r = trace(b);
            endcase
            pending_hits.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_hit got);
            t_hit exp;
            if (pending_hits.size() == 0) begin
                report("result with nothing pending");
                return;
            end
            exp = pending_hits.pop_front();
            if (got.hit !== exp.hit)
                report($sformatf("hit got %0b exp %0b", got.hit, exp.hit));
            if (got.idx !== exp.idx)
                report($sformatf("sphere_index got %0d exp %0d", got.idx, exp.idx));
            if (got.distance !== exp.distance)
                report($sformatf("hit_distance got %h exp %h", got.distance, exp.distance));
            if (got.status !== exp.status)
                report($sformatf("load_status got %0b exp %0b", got.status, exp.status));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_command = '0;
    logic signed [31:0] i_center_x = '0, i_center_y = '0, i_center_z = '0;
    logic [30:0]        i_sphere_radius = '0;
    logic signed [31:0] i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic signed [31:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic [30:0]        i_far_limit = '0;
    logic               o_result_valid, o_hit, o_load_status, o_cfg_ready;
    logic [3:0]         o_sphere_index;
    logic [30:0]        o_hit_distance;
    logic               i_cfg_valid = 1'b0;
    logic [0:0]         i_cfg_index = '0;
    logic [30:0]        i_cfg_data = '0;

    ray_sphere_closest_hit_core DUT (.*);

    always #4 i_clk = ~i_clk;

    hit_scoreboard sb = new();
    int            cycles = 0;
    int            sent = 0;
    logic signed [31:0] stored_x[$], stored_y[$], stored_z[$];

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_ray_sphere_closest_hit_core: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_result('{hit: o_hit, idx: o_sphere_index, distance: o_hit_distance,
                              status: o_load_status});
    end

    // leaves start high; caller lowers it on a gap
    task send_beat(t_beat b);
        start <= 1'b1;
        i_command <= b.cmd;
        i_center_x <= b.cx; i_center_y <= b.cy; i_center_z <= b.cz;
        i_sphere_radius <= b.radius;
        i_origin_x <= b.ox; i_origin_y <= b.oy; i_origin_z <= b.oz;
        i_dir_x <= b.dx; i_dir_y <= b.dy; i_dir_z <= b.dz;
        i_far_limit <= b.far_lim;
        do @(posedge i_clk); while (busy);
        sb.note_beat(b);
        if (b.cmd == CMD_CLEAR) begin
            stored_x.delete(); stored_y.delete(); stored_z.delete();
        end else if (b.cmd == CMD_APPEND && stored_x.size() < N_SLOTS) begin
            stored_x.push_back(b.cx); stored_y.push_back(b.cy); stored_z.push_back(b.cz);
        end
        sent++;
    endtask

    task send_idle(t_beat b, bit allow_gap);
        int gap;
        send_beat(b);
        gap = (allow_gap && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task write_regs(logic [30:0] p, logic [30:0] s);
        start <= 1'b0;
        while (sb.pending_hits.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        for (int i = 0; i < 2; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (i == 0) ? CFG_PRIMARY_NEAR : CFG_SECONDARY_NEAR;
            i_cfg_data <= (i == 0) ? p : s;
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_reg((i == 0) ? CFG_PRIMARY_NEAR : CFG_SECONDARY_NEAR, (i == 0) ? p : s);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function t_beat blank(t_command c);
        t_beat b;
        b = '{cmd: c, cx: '0, cy: '0, cz: '0, radius: '0, ox: '0, oy: '0, oz: '0,
              dx: '0, dy: '0, dz: '0, far_lim: DIST_ONES};
        return b;
    endfunction

    function logic signed [31:0] near_coord();
        return $signed($urandom_range(0, 40 * 65536)) - 20 * UNIT;
    endfunction

    function t_beat noise_beat();
        t_beat b;
        b.cmd = t_command'($urandom_range(0, 3));
        b.cx = $urandom; b.cy = $urandom; b.cz = $urandom;
        b.radius = 31'($urandom);
        b.ox = $urandom; b.oy = $urandom; b.oz = $urandom;
        b.dx = $urandom; b.dy = $urandom; b.dz = $urandom;
        b.far_lim = 31'($urandom);
        return b;
    endfunction

    function t_beat aimed_query();
        t_beat b;
        int    k, sh;
        b = blank($urandom_range(0, 1) ? CMD_PRIMARY : CMD_SECONDARY);
        b.ox = near_coord(); b.oy = near_coord(); b.oz = near_coord();
        sh = $urandom_range(0, 4);
        if (stored_x.size() > 0) begin
            k = $urandom_range(0, stored_x.size() - 1);
            b.dx = (stored_x[k] - b.ox) >>> sh;
            b.dy = (stored_y[k] - b.oy) >>> sh;
            b.dz = (stored_z[k] - b.oz) >>> sh;
        end else begin
            b.dx = near_coord(); b.dy = near_coord(); b.dz = near_coord();
        end
        b.dx += $signed($urandom_range(0, 8191)) - 4096;
        if ($urandom_range(0, 2) == 0) b.far_lim = 31'($urandom_range(0, 40 * 65536));
        return b;
    endfunction

    function t_beat sphere_beat();
        t_beat b;
        b = blank(CMD_APPEND);
        b.cx = near_coord(); b.cy = near_coord(); b.cz = near_coord();
        b.radius = 31'($urandom_range(65536 / 4, 6 * 65536));
        return b;
    endfunction

    task random_phase(int n_beats, bit allow_gap);
        int stop, n;
        stop = sent + n_beats;
        while (sent < stop) begin
            if ($urandom_range(0, 4) != 0) send_idle(blank(CMD_CLEAR), allow_gap);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 4);
            repeat (n) send_idle(sphere_beat(), allow_gap);
            n = $urandom_range(1, 5);
            repeat (n) begin
                if ($urandom_range(0, 5) == 0) send_idle(noise_beat(), allow_gap);
                else send_idle(aimed_query(), allow_gap);
            end
        end
    endtask

    initial begin
        t_beat b;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, ties, misses, saturation, extremes, full table
        send_idle(blank(CMD_PRIMARY), 1'b0);
        b = blank(CMD_APPEND); b.cz = 10 * UNIT; b.radius = 31'd65536;
        send_idle(b, 1'b0);
        send_idle(b, 1'b0);
        b = blank(CMD_PRIMARY); b.dz = UNIT;
        send_idle(b, 1'b0);
        send_idle(blank(CMD_SECONDARY), 1'b0);
        b.dz = -UNIT;
        send_idle(b, 1'b0);
        b.dz = '0; b.dy = UNIT;
        send_idle(b, 1'b0);
        b.dy = '0; b.dz = UNIT; b.far_lim = 31'd1;
        send_idle(b, 1'b0);
        b.dz = 32'sd1; b.far_lim = DIST_ONES;
        send_idle(b, 1'b0);
        b = blank(CMD_APPEND);
        b.cx = 32'sh7FFF_FFFF; b.cy = 32'sh8000_0000; b.cz = 32'sh8000_0000;
        b.radius = DIST_ONES;
        send_idle(b, 1'b0);
        b = blank(CMD_SECONDARY);
        b.ox = 32'sh8000_0000; b.oy = 32'sh7FFF_FFFF; b.oz = 32'sh8000_0000;
        b.dx = 32'sh7FFF_FFFF; b.dy = 32'sh8000_0000; b.dz = 32'sh7FFF_FFFF;
        b.far_lim = DIST_ONES - 31'd1;
        send_idle(b, 1'b0);
        send_idle(blank(CMD_CLEAR), 1'b0);
        repeat (17) send_idle(sphere_beat(), 1'b0);
        send_idle(aimed_query(), 1'b0);

        write_regs('0, '0);
        random_phase(150, 1'b1);
        write_regs(DIST_ONES, DIST_ONES);
        random_phase(30, 1'b1);
        write_regs(31'($urandom_range(0, 2 * 65536)), 31'($urandom_range(0, 65536)));
        random_phase(150, 1'b1);
        write_regs(PRIMARY_NEAR_RESET, SECONDARY_NEAR_RESET);
        random_phase(120, 1'b1);
        random_phase(80, 1'b0);

        start <= 1'b0;
        while (sb.pending_hits.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
            $display("tb_ray_sphere_closest_hit_core: clean");
        end else begin
            $display("tb_ray_sphere_closest_hit_core: errors");
        end
        $finish;
    end

endmodule
